// ----- hdl/gdfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared constants, codes and controller/datapath interface types for the
// grid depth-first search unit.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int DIM_W      = 7;
  localparam int COORD_IN_W = 6;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int DIR_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  // neighbor order
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic start;
    logic step;
    logic test;
    logic pop;
    logic publish;
  } gdfs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic range_err;
    logic src_is_tgt;
    logic dir_done;
    logic stack_empty;
    logic nb_ok;
    logic nb_visited;
    logic nb_is_tgt;
    logic out_free;
  } gdfs_status_t;

endpackage

// ----- hdl/gdfs_datapath.sv -----
// ----------------------------------------------------------------------------
// gdfs_datapath
// Configuration registers, visited map, walk stack, current cell, neighbor
// generation, cell counter and result register.
// ----------------------------------------------------------------------------
module gdfs_datapath
  import gdfs_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_wr_data,
  input  logic [COORD_IN_W-1:0]  in_source_x,
  input  logic [COORD_IN_W-1:0]  in_source_y,
  input  logic [COORD_IN_W-1:0]  in_target_x,
  input  logic [COORD_IN_W-1:0]  in_target_y,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   out_found,
  output logic                   out_range_error,
  output logic [COUNT_W-1:0]     out_cells_entered,
  input  gdfs_cmd_t              cmd,
  output gdfs_status_t           status
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW    = XW + YW + DIR_W;

  function automatic logic [CW-1:0] cell_addr(input logic [YW-1:0] y,
                                               input logic [XW-1:0] x);
    cell_addr = CW'(32'(y) * MAX_COLS + 32'(x));
  endfunction

  logic [DIM_W-1:0]   grid_rows_r, grid_cols_r;
  logic [8:0]         rows_c, cols_c;

  logic [XW-1:0]      sx_r, tx_r, cur_x_r, nb_x_r, nb_x;
  logic [YW-1:0]      sy_r, ty_r, cur_y_r, nb_y_r, nb_y;
  logic [DIR_W-1:0]   dir_r;
  logic               err_r, found_r;
  logic [COUNT_W-1:0] count_r;
  logic [CW-1:0]      sp_r;
  logic [CW-1:0]      clr_addr_r;
  logic               nb_ok;
  logic               req_err;

  logic               vis_mem [CELLS];
  logic               vis_rd_r;
  logic [SW-1:0]      stk_mem [CELLS];
  logic [SW-1:0]      stk_rd_r;

  logic               out_valid_r, out_found_r, out_err_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               push;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_W'(64);
      grid_cols_r <= DIM_W'(64);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_ROWS: grid_rows_r <= cfg_wr_data;
        CFG_GRID_COLS: grid_cols_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign rows_c = ({2'b0, grid_rows_r} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, grid_rows_r};
  assign cols_c = ({2'b0, grid_cols_r} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, grid_cols_r};

  assign req_err = ({3'b0, in_source_x} >= cols_c) || ({3'b0, in_source_y} >= rows_c) ||
                   ({3'b0, in_target_x} >= cols_c) || ({3'b0, in_target_y} >= rows_c);

  // neighbor of the current cell in the current direction
  always_comb begin
    nb_x  = cur_x_r;
    nb_y  = cur_y_r;
    nb_ok = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nb_y  = cur_y_r + YW'(1);
        nb_ok = (9'(cur_y_r) + 9'd1) < rows_c;
      end
      DIR_RIGHT: begin
        nb_x  = cur_x_r + XW'(1);
        nb_ok = (9'(cur_x_r) + 9'd1) < cols_c;
      end
      DIR_DOWN: begin
        nb_y  = cur_y_r - YW'(1);
        nb_ok = cur_y_r != '0;
      end
      DIR_LEFT: begin
        nb_x  = cur_x_r - XW'(1);
        nb_ok = cur_x_r != '0;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign push = cmd.test && !vis_rd_r && !status.nb_is_tgt;

  // visited map
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      vis_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.start && !err_r) begin
      vis_mem[cell_addr(sy_r, sx_r)] <= 1'b1;
    end else if (cmd.test && !vis_rd_r) begin
      vis_mem[cell_addr(nb_y_r, nb_x_r)] <= 1'b1;
    end
    vis_rd_r <= vis_mem[cell_addr(nb_y, nb_x)];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[sp_r] <= {cur_x_r, cur_y_r, dir_r};
    end
    stk_rd_r <= stk_mem[sp_r - CW'(1)];
  end

  // walk control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      sp_r       <= '0;
      dir_r      <= DIR_UP;
    end else begin
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + CW'(1);
      end
      if (cmd.start) begin
        sp_r  <= '0;
        dir_r <= DIR_UP;
      end else if (cmd.step) begin
        dir_r <= dir_r + DIR_W'(1);
      end else if (push) begin
        sp_r  <= sp_r + CW'(1);
        dir_r <= DIR_UP;
      end else if (cmd.pop) begin
        sp_r  <= sp_r - CW'(1);
        dir_r <= stk_rd_r[DIR_W-1:0];
      end
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r    <= XW'({3'b0, in_source_x});
      sy_r    <= YW'({3'b0, in_source_y});
      tx_r    <= XW'({3'b0, in_target_x});
      ty_r    <= YW'({3'b0, in_target_y});
      err_r   <= req_err;
      found_r <= 1'b0;
      count_r <= '0;
    end
    if (cmd.start) begin
      cur_x_r <= sx_r;
      cur_y_r <= sy_r;
      found_r <= !err_r && (sx_r == tx_r) && (sy_r == ty_r);
      count_r <= err_r ? '0 : COUNT_W'(1);
    end
    if (cmd.step) begin
      nb_x_r <= nb_x;
      nb_y_r <= nb_y;
    end
    if (cmd.test && !vis_rd_r) begin
      count_r <= count_r + COUNT_W'(1);
      if (status.nb_is_tgt) begin
        found_r <= 1'b1;
      end
    end
    if (push) begin
      cur_x_r <= nb_x_r;
      cur_y_r <= nb_y_r;
    end
    if (cmd.pop) begin
      cur_x_r <= stk_rd_r[SW-1 -: XW];
      cur_y_r <= stk_rd_r[DIR_W +: YW];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found_r <= found_r;
      out_err_r   <= err_r;
      out_count_r <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_range_error   = out_err_r;
  assign out_cells_entered = out_count_r;

  assign status.clear_last  = clr_addr_r == CW'(CELLS - 1);
  assign status.range_err   = err_r;
  assign status.src_is_tgt  = (sx_r == tx_r) && (sy_r == ty_r);
  assign status.dir_done    = dir_r == DIR_DONE;
  assign status.stack_empty = sp_r == '0;
  assign status.nb_ok       = nb_ok;
  assign status.nb_visited  = vis_rd_r;
  assign status.nb_is_tgt   = (nb_x_r == tx_r) && (nb_y_r == ty_r);
  assign status.out_free    = !out_valid_r || !out_stall;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sp_r != '0)
    else $error("pop from empty walk stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> sp_r != '1)
    else $error("walk stack overflow");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r && (out_count_r == $past(count_r)))
    else $error("result not presented after publish");

  a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish && err_r |-> (count_r == '0) && !found_r)
    else $error("range error result carries search data");

endmodule

// ----- hdl/gdfs_controller.sv -----
// ----------------------------------------------------------------------------
// gdfs_controller
// Sequencer for the map clearing pass, request intake, neighbor walk,
// backtracking and result hand-off.
// ----------------------------------------------------------------------------
module gdfs_controller
  import gdfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  gdfs_status_t status,
  output gdfs_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (status.range_err || status.src_is_tgt) state_nxt = S_DONE;
        else state_nxt = S_STEP;
      end
      S_STEP: begin
        if (status.dir_done) begin
          if (status.stack_empty) state_nxt = S_DONE;
          else state_nxt = S_POP;
        end else begin
          cmd.step = 1'b1;
          if (status.nb_ok) state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (!status.nb_visited && status.nb_is_tgt) state_nxt = S_DONE;
        else state_nxt = S_STEP;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_STEP;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_clear_first: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLEAR)
    else $error("reset does not start the clearing pass");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> status.out_free)
    else $error("result overwrites a pending result");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_START)
    else $error("request load not followed by start");

endmodule

// ----- hdl/grid_depth_first_search_unit.sv -----
// ----------------------------------------------------------------------------
// grid_depth_first_search_unit
// Depth-first walk on a 4-connected grid with a persistent visited map.
// An out-of-range or source-is-target request goes from the start state
// straight to the result; otherwise each in-grid neighbor check passes a step
// and a test state, an off-grid direction a step state only, and a backtrack a
// pop state and then a step state.
// One request in flight; the next is taken once the result sits in the
// output register. After reset a clearing pass over all MAX_ROWS*MAX_COLS
// cells wipes the visited map before the first request is accepted.
// ----------------------------------------------------------------------------
module grid_depth_first_search_unit
  import gdfs_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_IN_W-1:0] in_source_x,
  input  logic [COORD_IN_W-1:0] in_source_y,
  input  logic [COORD_IN_W-1:0] in_target_x,
  input  logic [COORD_IN_W-1:0] in_target_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic                  out_range_error,
  output logic [COUNT_W-1:0]    out_cells_entered
);

  gdfs_cmd_t    cmd;
  gdfs_status_t status;

  gdfs_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gdfs_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_source_x       (in_source_x),
    .in_source_y       (in_source_y),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_range_error   (out_range_error),
    .out_cells_entered (out_cells_entered),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// ----- test/tb_grid_depth_first_search_unit.sv -----
// ----------------------------------------------------------------------------
// tb_grid_depth_first_search_unit
// Self-checking bench for the grid depth-first search unit. A scoreboard keeps
// its own visited map and grid size and replays each accepted request as a
// depth-first walk for the expected result beat. Directed requests cover zero,
// unit and clamped grid sizes first, full size last. Both channels idle at
// random, and random phases grow the grid so later searches find fresh cells.
// ----------------------------------------------------------------------------
module tb_grid_depth_first_search_unit;
  import gdfs_pkg::*;

  typedef logic [COORD_IN_W-1:0] coord_t;

  typedef struct packed {
    logic               found;
    logic               range_error;
    logic [COUNT_W-1:0] cells_entered;
  } search_result_t;

  typedef struct {
    int unsigned      x;
    int unsigned      y;
    logic [DIR_W-1:0] dir;
  } open_cell_t;

  class search_scoreboard;
    bit                 visited [DEF_MAX_ROWS*DEF_MAX_COLS];
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    search_result_t     expected_q [$];
    int unsigned        errors;

    function new();
      rows_reg = DIM_W'(DEF_MAX_ROWS);
      cols_reg = DIM_W'(DEF_MAX_COLS);
      errors = 0;
      foreach (visited[i]) visited[i] = 1'b0;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      if (idx == CFG_GRID_ROWS) rows_reg = value;
      else if (idx == CFG_GRID_COLS) cols_reg = value;
    endfunction

    function int unsigned used_rows();
      return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
    endfunction

    function int unsigned used_cols();
      return (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(coord_t sx, coord_t sy, coord_t tx, coord_t ty);
      int unsigned    rows;
      int unsigned    cols;
      int unsigned    nx;
      int unsigned    ny;
      int unsigned    count;
      bit             hit;
      bit             ok;
      open_cell_t     trail [$];
      open_cell_t     top;
      open_cell_t     fresh;
      search_result_t res;
      rows = used_rows();
      cols = used_cols();
      res = '0;
      hit = 1'b0;
      if (sx >= cols || sy >= rows || tx >= cols || ty >= rows) begin
        res.range_error = 1'b1;
      end else begin
        visited[sy*DEF_MAX_COLS + sx] = 1'b1;
        count = 1;
        if (sx == tx && sy == ty) begin
          hit = 1'b1;
        end else begin
          fresh = '{x: sx, y: sy, dir: DIR_UP};
          trail.insert(trail.size(), fresh);
        end
        while (trail.size() > 0 && !hit) begin
          top = trail[trail.size()-1];
          if (top.dir >= DIR_DONE) begin
            void'(trail.pop_back());
          end else begin
            trail[trail.size()-1].dir = top.dir + 1'b1;
            nx = top.x;
            ny = top.y;
            ok = 1'b0;
            case (top.dir)
              DIR_UP:    if (top.y + 1 < rows) begin ny = top.y + 1; ok = 1'b1; end
              DIR_RIGHT: if (top.x + 1 < cols) begin nx = top.x + 1; ok = 1'b1; end
              DIR_DOWN:  if (top.y > 0) begin ny = top.y - 1; ok = 1'b1; end
              default:   if (top.x > 0) begin nx = top.x - 1; ok = 1'b1; end
            endcase
            if (ok && !visited[ny*DEF_MAX_COLS + nx]) begin
              visited[ny*DEF_MAX_COLS + nx] = 1'b1;
              count++;
              if (nx == tx && ny == ty) begin
                hit = 1'b1;
              end else begin
                fresh = '{x: nx, y: ny, dir: DIR_UP};
                trail.insert(trail.size(), fresh);
              end
            end
          end
        end
        res.found = hit;
        res.cells_entered = count[COUNT_W-1:0];
      end
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_result(logic found, logic range_error, logic [COUNT_W-1:0] cells);
      search_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (range_error !== want.range_error) begin
        $error("range_error: expected %0d, actual %0d", want.range_error, range_error);
        errors++;
      end
      if (cells !== want.cells_entered) begin
        $error("cells_entered: expected %0d, actual %0d", want.cells_entered, cells);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_ROWS;
  logic [DIM_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  coord_t                in_source_x = '0;
  coord_t                in_source_y = '0;
  coord_t                in_target_x = '0;
  coord_t                in_target_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic                  out_range_error;
  logic [COUNT_W-1:0]    out_cells_entered;

  bit                    calm = 1'b0;
  search_scoreboard      board = new();

  grid_depth_first_search_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_x       (in_source_x),
    .in_source_y       (in_source_y),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_range_error   (out_range_error),
    .out_cells_entered (out_cells_entered)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_found, out_range_error, out_cells_entered);
    end
  end

  task automatic send_request(input coord_t sx, input coord_t sy, input coord_t tx,
                              input coord_t ty);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_source_x <= sx;
    in_source_y <= sy;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(sx, sy, tx, ty);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_GRID_ROWS;
    cfg_wr_data <= rows;
    @(posedge clk);
    board.set_dim(CFG_GRID_ROWS, rows);
    cfg_index   <= CFG_GRID_COLS;
    cfg_wr_data <= cols;
    @(posedge clk);
    board.set_dim(CFG_GRID_COLS, cols);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(int unsigned reach);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 10) return DIM_W'($urandom_range(DEF_MAX_ROWS + 1, 127));
    if (roll < 20) return DIM_W'(1);
    return DIM_W'($urandom_range(1, reach));
  endfunction

  function automatic coord_t pick_coord(int unsigned span);
    if (span == 0 || $urandom_range(0, 99) < 15) return coord_t'($urandom_range(0, 63));
    return coord_t'($urandom_range(0, span - 1));
  endfunction

  initial begin
    int unsigned reach;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero rows: nothing is in range
    set_grid(DIM_W'(0), DIM_W'(64));
    send_request(6'd0, 6'd0, 6'd0, 6'd0);
    send_request(6'd63, 6'd63, 6'd63, 6'd63);
    settle();

    // single cell
    set_grid(DIM_W'(1), DIM_W'(1));
    send_request(6'd0, 6'd0, 6'd0, 6'd0);
    send_request(6'd0, 6'd0, 6'd0, 6'd1);
    send_request(6'd1, 6'd0, 6'd0, 6'd0);
    settle();

    // small grid, revisits and source on an old cell
    set_grid(DIM_W'(3), DIM_W'(2));
    send_request(6'd0, 6'd0, 6'd1, 6'd2);
    send_request(6'd1, 6'd2, 6'd0, 6'd0);
    send_request(6'd0, 6'd1, 6'd0, 6'd1);
    send_request(6'd1, 6'd1, 6'd0, 6'd5);
    settle();

    // rows above the maximum clamp
    set_grid(DIM_W'(127), DIM_W'(3));
    send_request(6'd0, 6'd0, 6'd2, 6'd63);
    send_request(6'd2, 6'd63, 6'd0, 6'd0);
    send_request(6'd1, 6'd40, 6'd1, 6'd10);
    settle();

    // cols above the maximum clamp
    set_grid(DIM_W'(4), DIM_W'(65));
    send_request(6'd63, 6'd0, 6'd63, 6'd3);
    send_request(6'd10, 6'd2, 6'd0, 6'd0);
    send_request(6'd63, 6'd3, 6'd62, 6'd3);
    settle();

    // random phases, grid grows so fresh cells keep turning up
    for (int phase = 0; phase < 8; phase++) begin
      reach = 8 + 8 * phase;
      if (reach > DEF_MAX_ROWS) reach = DEF_MAX_ROWS;
      set_grid(pick_dim(reach), pick_dim(reach));
      calm = (phase == 3);
      for (int n = 0; n < 12; n++) begin
        send_request(pick_coord(board.used_cols()), pick_coord(board.used_rows()),
                     pick_coord(board.used_cols()), pick_coord(board.used_rows()));
      end
      settle();
    end
    calm = 1'b0;

    // full grid sweep
    set_grid(DIM_W'(64), DIM_W'(64));
    send_request(6'd0, 6'd0, 6'd63, 6'd63);
    send_request(6'd63, 6'd63, 6'd0, 6'd0);
    send_request(6'd31, 6'd17, 6'd5, 6'd60);
    settle();

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
